// File: rtl/rwa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the reno window ack update block
// no dependencies; used by every module of the block

package rwa_pkg;

  localparam int unsigned ACK_W = 27;
  localparam int unsigned CNT_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX     = 16'hFFFF;
  localparam logic [CNT_W-1:0] WINDOW_INIT = 16'd2;
  localparam logic [CNT_W-1:0] THRESH_INIT = 16'hFFFF;

  typedef struct packed {
    logic [ACK_W-1:0] ack_sequence;
    logic [CNT_W-1:0] peak_in_flight;
    logic             window_limited;
  } ack_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] window_size;
    logic [CNT_W-1:0] increase_credit;
  } window_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_SLOW,
    S_BUMP,
    S_ADD,
    S_CMP,
    S_DIV,
    S_APPLY,
    S_DONE
  } state_t;

endpackage

// File: rtl/rwa_divider.sv
`timescale 1ns / 1ps
// restoring serial divider, one quotient bit per cycle
// depends on rwa_pkg for the counter width

module rwa_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rwa_pkg::CNT_W-1:0] dividend,
  input  logic [rwa_pkg::CNT_W-1:0] divisor,
  output logic                     busy,
  output logic [rwa_pkg::CNT_W-1:0] quotient,
  output logic [rwa_pkg::CNT_W-1:0] remainder
);

  localparam int unsigned W  = rwa_pkg::CNT_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    rem_shift;
  logic [W:0]    rem_sub;
  logic          fits;

  assign rem_shift = {rem, quo[W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= CW'(W);
    end else if (run) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (run) begin
      rem <= fits ? rem_sub[W-1:0] : rem_shift[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign busy      = run;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/reno_window_ack_update_core.sv
`timescale 1ns / 1ps
// Congestion window update per acknowledgement: a small sequencer walks each ack
// through slow start and additive increase, sharing one serial divider for the
// credit over window step. An ack passes, in order, idle, eval, then as needed slow
// start, bump, add, compare, divide and apply (divide only when the credit reaches
// the window), and done. One ack is in work at a time; a finished result waits in
// the output register and the next ack is taken while it waits, while a second
// finished result holds the sequencer until the output register frees.
// depends on rwa_pkg and rwa_divider

module reno_window_ack_update_core #(
  parameter int unsigned SEQ_BITS = 27
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [15:0]          cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rwa_pkg::ack_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rwa_pkg::window_item_t out_data
);

  localparam int unsigned W  = rwa_pkg::CNT_W;
  localparam int unsigned NW = SEQ_BITS + 1;
  localparam int unsigned SW = ((NW > W) ? NW : W) + 1;

  rwa_pkg::state_t state;
  rwa_pkg::state_t state_next;

  logic [W-1:0]        thresh;
  logic [SEQ_BITS-1:0] prev_ack;
  logic [W-1:0]        window_cnt;
  logic [W-1:0]        credit_cnt;
  logic [SW-1:0]       n_cnt;
  logic [W-1:0]        peak;
  logic                wlim;
  logic [W-1:0]        divisor;

  logic [32:0]         ack_wide;
  logic [SEQ_BITS-1:0] ack_seq;
  logic [SEQ_BITS-1:0] ack_diff;
  logic [SW-1:0]       n_first;
  logic                in_slow;
  logic                limited;
  logic [SW-1:0]       ss_sum;
  logic [W-1:0]        ss_new;
  logic [SW-1:0]       ss_left;
  logic [W-1:0]        w_guard;
  logic [SW:0]         credit_sum;
  logic [W-1:0]        credit_sat;
  logic [W:0]          win_inc;
  logic [W-1:0]        win_inc_sat;
  logic [W:0]          win_add;
  logic [W-1:0]        win_add_sat;
  logic                credit_ge;
  logic                div_start;
  logic                div_busy;
  logic [W-1:0]        div_quo;
  logic [W-1:0]        div_rem;
  logic                out_load;

  // low SEQ_BITS of the ack, zero-extended when the field is narrower
  assign ack_wide = 33'(in_data.ack_sequence);
  assign ack_seq  = ack_wide[SEQ_BITS-1:0];
  assign ack_diff = ack_seq - prev_ack;
  assign n_first  = SW'(ack_diff) + SW'(1);

  assign in_slow = window_cnt < thresh;
  assign limited = in_slow ? ({1'b0, window_cnt} < {peak, 1'b0}) : wlim;
  assign ss_sum  = SW'(window_cnt) + n_cnt;

  // slow start: n_cnt holds window plus acked packets here
  assign ss_new  = (n_cnt > SW'(thresh)) ? thresh : n_cnt[W-1:0];
  assign ss_left = n_cnt - SW'(ss_new);

  assign w_guard = (window_cnt == '0) ? W'(1) : window_cnt;

  assign credit_sum = (SW+1)'(credit_cnt) + (SW+1)'(n_cnt);
  assign credit_sat = (credit_sum > (SW+1)'(rwa_pkg::CNT_MAX)) ? rwa_pkg::CNT_MAX
                                                               : credit_sum[W-1:0];

  assign win_inc     = (W+1)'(window_cnt) + (W+1)'(1);
  assign win_inc_sat = win_inc[W] ? rwa_pkg::CNT_MAX : win_inc[W-1:0];
  assign win_add     = (W+1)'(window_cnt) + (W+1)'(div_quo);
  assign win_add_sat = win_add[W] ? rwa_pkg::CNT_MAX : win_add[W-1:0];

  assign credit_ge = credit_cnt >= divisor;

  rwa_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (credit_cnt),
    .divisor   (divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rwa_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = rwa_pkg::S_EVAL;
        end
      end
      rwa_pkg::S_EVAL: begin
        if (!limited) begin
          state_next = rwa_pkg::S_DONE;
        end else if (in_slow) begin
          state_next = rwa_pkg::S_SLOW;
        end else begin
          state_next = rwa_pkg::S_BUMP;
        end
      end
      rwa_pkg::S_SLOW: begin
        state_next = (ss_left == '0) ? rwa_pkg::S_DONE : rwa_pkg::S_BUMP;
      end
      rwa_pkg::S_BUMP: state_next = rwa_pkg::S_ADD;
      rwa_pkg::S_ADD:  state_next = rwa_pkg::S_CMP;
      rwa_pkg::S_CMP: begin
        state_next = credit_ge ? rwa_pkg::S_DIV : rwa_pkg::S_DONE;
      end
      rwa_pkg::S_DIV: begin
        if (!div_busy) begin
          state_next = rwa_pkg::S_APPLY;
        end
      end
      rwa_pkg::S_APPLY: state_next = rwa_pkg::S_DONE;
      rwa_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = rwa_pkg::S_IDLE;
        end
      end
      default: state_next = rwa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      rwa_pkg::S_IDLE: in_stall  = 1'b0;
      rwa_pkg::S_CMP:  div_start = credit_ge;
      rwa_pkg::S_DONE: out_load  = !out_valid || !out_stall;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh     <= rwa_pkg::THRESH_INIT;
      prev_ack   <= '0;
      window_cnt <= rwa_pkg::WINDOW_INIT;
      credit_cnt <= '0;
    end else begin
      if (cfg_write_en) begin
        thresh <= cfg_write_data;
      end
      case (state)
        rwa_pkg::S_IDLE: begin
          if (in_valid) begin
            prev_ack <= ack_seq;
          end
        end
        rwa_pkg::S_SLOW: window_cnt <= ss_new;
        rwa_pkg::S_BUMP: begin
          // a full window of credit left over from before counts first
          if (credit_cnt >= w_guard) begin
            credit_cnt <= '0;
            window_cnt <= win_inc_sat;
          end
        end
        rwa_pkg::S_ADD: credit_cnt <= credit_sat;
        rwa_pkg::S_APPLY: begin
          credit_cnt <= div_rem;
          window_cnt <= win_add_sat;
        end
        default: begin
          window_cnt <= window_cnt;
        end
      endcase
    end
  end

  // per-ack working registers
  always_ff @(posedge clk) begin
    case (state)
      rwa_pkg::S_IDLE: begin
        n_cnt <= n_first;
        peak  <= in_data.peak_in_flight;
        wlim  <= in_data.window_limited;
      end
      rwa_pkg::S_EVAL: begin
        if (limited && in_slow) begin
          n_cnt <= ss_sum;
        end
      end
      rwa_pkg::S_SLOW: n_cnt <= ss_left;
      rwa_pkg::S_BUMP: divisor <= w_guard;
      default: begin
        n_cnt <= n_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.window_size     <= window_cnt;
      out_data.increase_credit <= credit_cnt;
    end
  end

endmodule

// File: rtl/rwa_checker.sv
`timescale 1ns / 1ps
// port-level checks for the reno window ack update core, bound to the top level
// depends on rwa_pkg and reno_window_ack_update_core

module rwa_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input rwa_pkg::window_item_t out_data
);

  // an accepted transaction makes the block busy in the following cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall
  ) else $error("input taken on two consecutive cycles");

  // a result appears only after the block was busy
  a_result_after_work: assert property (
    @(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result without preceding work");

  // window never drops below its reset size
  a_window_floor: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> out_data.window_size >= rwa_pkg::WINDOW_INIT
  ) else $error("window below two");

  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)
  ) else $error("stalled result changed");

endmodule

bind reno_window_ack_update_core rwa_checker u_rwa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/tb_reno_window_ack_update_core.sv
`timescale 1ns / 1ps
// self-checking bench for reno_window_ack_update_core: a script of directed acks and
// several randomized threshold phases, checked against scripted values or an in-bench window predictor
// depends on rwa_pkg and the block's rtl

module tb_reno_window_ack_update_core;

  localparam int unsigned ACK_W       = rwa_pkg::ACK_W;
  localparam int unsigned CNT_W       = rwa_pkg::CNT_W;
  localparam int unsigned SEQ_BITS    = ACK_W;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned OPEN_ROWS   = 13;
  localparam int unsigned SCRIPT_ROWS = 21;

  typedef struct packed {
    logic                  reconfig;
    logic [CNT_W-1:0]      threshold;
    rwa_pkg::ack_item_t    item;
    logic                  typed;
    rwa_pkg::window_item_t want;
  } stim_row_t;

  // reconfig, threshold, ack, peak, limited, typed, window, credit
  localparam stim_row_t SCRIPT [SCRIPT_ROWS] = '{
    // idle after reset: no growth, window stays at two
    {1'b0, 16'd0, 27'd0, 16'd0, 1'b0, 1'b1, 16'd2, 16'd0},
    {1'b0, 16'd0, 27'h7FFFFFF, 16'd1, 1'b1, 1'b1, 16'd2, 16'd0},
    // ack wraps past zero, slow start takes all five packets
    {1'b0, 16'd0, 27'd3, 16'd2, 1'b0, 1'b1, 16'd7, 16'd0},
    // repeated ack still counts one packet
    {1'b0, 16'd0, 27'd3, 16'hFFFF, 1'b1, 1'b1, 16'd8, 16'd0},
    {1'b0, 16'd0, 27'd5, 16'd4, 1'b0, 1'b1, 16'd8, 16'd0},
    // slow start hits the threshold, leftover goes to credit
    {1'b1, 16'd12, 27'd9, 16'd100, 1'b0, 1'b0, 16'd0, 16'd0},
    {1'b0, 16'd0, 27'd39, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0},
    {1'b0, 16'd0, 27'd39, 16'hFFFF, 1'b0, 1'b0, 16'd0, 16'd0},
    {1'b0, 16'd0, 27'd45, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0},
    // slow start lands exactly on the threshold
    {1'b1, 16'd20, 27'd49, 16'd100, 1'b0, 1'b0, 16'd0, 16'd0},
    {1'b0, 16'd0, 27'd50, 16'h8000, 1'b1, 1'b0, 16'd0, 16'd0},
    {1'b1, 16'hFFFF, 27'd250, 16'h7FFF, 1'b0, 1'b0, 16'd0, 16'd0},
    {1'b0, 16'd0, 27'd1249, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0},
    // closing rows: saturation of window and credit
    {1'b1, 16'hFFFF, 27'd1000, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0},
    // ack just below the previous one covers the whole sequence space
    {1'b0, 16'd0, 27'd999, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'd0},
    {1'b0, 16'd0, 27'd66533, 16'd0, 1'b1, 1'b1, 16'hFFFF, 16'd0},
    {1'b0, 16'd0, 27'd132066, 16'd0, 1'b1, 1'b1, 16'hFFFF, 16'd65534},
    // credit clips before the division
    {1'b0, 16'd0, 27'd132068, 16'd0, 1'b1, 1'b1, 16'hFFFF, 16'd0},
    {1'b0, 16'd0, 27'd132069, 16'd0, 1'b1, 1'b1, 16'hFFFF, 16'd2},
    {1'b0, 16'd0, 27'h7FFFFFF, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'd2},
    {1'b1, 16'd2, 27'd0, 16'd0, 1'b1, 1'b1, 16'hFFFF, 16'd4}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [CNT_W-1:0]      cfg_write_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  rwa_pkg::ack_item_t    in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rwa_pkg::window_item_t out_data;

  // predictor state
  logic [SEQ_BITS-1:0] last_ack;
  logic [CNT_W-1:0]    cwnd;
  logic [CNT_W-1:0]    credit;
  logic [CNT_W-1:0]    ssthresh;

  rwa_pkg::window_item_t expected_windows[$];
  rwa_pkg::window_item_t head_window;
  int unsigned  errors = 0;
  int unsigned  acks_sent = 0;
  int unsigned  windows_checked = 0;
  int unsigned  threshold_writes = 0;
  int unsigned  cycle_count = 0;
  logic         quiet = 1'b0;
  logic         hold_request = 1'b0;
  logic         hold_done;
  int unsigned  hold_run;
  int unsigned  stall_run;

  reno_window_ack_update_core #(.SEQ_BITS(SEQ_BITS)) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned clip16(input longint unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  // advances the predicted window state by one ack and returns the new window
  function automatic rwa_pkg::window_item_t reno_advance(input rwa_pkg::ack_item_t ack);
    logic [SEQ_BITS-1:0]   seq_now;
    logic [SEQ_BITS-1:0]   seq_gap;
    longint unsigned       pkts, win, cred, peak, grown, divisor, whole, thr;
    logic                  in_slow, limited, grow;
    rwa_pkg::window_item_t after_ack;
    seq_now = ack.ack_sequence[SEQ_BITS-1:0];
    seq_gap = seq_now - last_ack;
    pkts = 64'(seq_gap);
    pkts = pkts + 1;
    win = 64'(cwnd);
    cred = 64'(credit);
    peak = 64'(ack.peak_in_flight);
    thr = 64'(ssthresh);
    in_slow = (win < thr);
    limited = in_slow ? (win < 2 * peak) : ack.window_limited;
    grow = limited;
    if (limited && in_slow) begin
      grown = (win + pkts > thr) ? thr : win + pkts;
      pkts = pkts - (grown - win);
      win = grown;
      if (pkts == 0) grow = 1'b0;
    end
    if (grow) begin
      divisor = (win == 0) ? 1 : win;
      if (cred >= divisor) begin
        cred = 0;
        win = clip16(win + 1);
      end
      cred = clip16(cred + pkts);
      if (cred >= divisor) begin
        whole = cred / divisor;
        cred = cred - whole * divisor;
        win = clip16(win + whole);
      end
    end
    last_ack = seq_now;
    cwnd = win[CNT_W-1:0];
    credit = cred[CNT_W-1:0];
    after_ack.window_size = cwnd;
    after_ack.increase_credit = credit;
    return after_ack;
  endfunction

  // mostly in-order acks with small steps; wide steps and wild acks are rare
  function automatic rwa_pkg::ack_item_t random_ack(input int unsigned wide_span,
                                                    input logic noisy);
    rwa_pkg::ack_item_t a;
    int unsigned        pick;
    int unsigned        step;
    pick = $urandom_range(0, 199);
    if (pick < 150) step = $urandom_range(0, 3);
    else if (pick < 190) step = $urandom_range(0, 63);
    else step = $urandom_range(0, wide_span);
    if (noisy && pick >= 198) a.ack_sequence = ACK_W'($urandom);
    else a.ack_sequence = ACK_W'(last_ack + step);
    if ($urandom_range(0, 1)) a.peak_in_flight = CNT_W'($urandom);
    else a.peak_in_flight = CNT_W'($urandom_range(0, cwnd));
    a.window_limited = 1'($urandom_range(0, 1));
    return a;
  endfunction

  task automatic flag_error(input string what, input rwa_pkg::window_item_t want,
                            input rwa_pkg::window_item_t got);
    errors++;
    if (errors <= 10)
      $display("error %0d, %s: expected window %0d credit %0d, got window %0d credit %0d",
               errors, what, want.window_size, want.increase_credit,
               got.window_size, got.increase_credit);
  endtask

  task automatic offer_ack(input rwa_pkg::ack_item_t item, input logic typed,
                           input rwa_pkg::window_item_t want);
    rwa_pkg::window_item_t predicted;
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = reno_advance(item);
    expected_windows.push_back(typed ? want : predicted);
    acks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    ssthresh = value;
    threshold_writes++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic walk_script(input int unsigned first, input int unsigned last);
    for (int unsigned r = first; r <= last; r++) begin
      if (SCRIPT[r].reconfig) write_threshold(SCRIPT[r].threshold);
      sender_gap();
      offer_ack(SCRIPT[r].item, SCRIPT[r].typed, SCRIPT[r].want);
    end
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] threshold, input int unsigned items,
                           input int unsigned wide_span, input logic noisy,
                           input logic hold_mid, input logic pause_mid);
    write_threshold(threshold);
    for (int unsigned i = 0; i < items; i++) begin
      if (i == items / 2) begin
        // receiver backs up while acks keep coming, or the sender pauses until all results are drained
        if (hold_mid) hold_request <= 1'b1;
        if (pause_mid) wait_drained();
      end
      sender_gap();
      offer_ack(random_ack(wide_span, noisy), 1'b0, '0);
    end
  endtask

  // receiver: random stall bursts plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
      hold_run <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_run <= LONG_HOLD - 1;
      hold_done <= 1'b1;
    end else if (hold_run != 0) begin
      out_stall <= 1'b1;
      hold_run <= hold_run - 1;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_windows.size() == 0) begin
        flag_error("result with nothing pending", '0, out_data);
      end else begin
        head_window = expected_windows.pop_front();
        windows_checked++;
        if (out_data.window_size !== head_window.window_size ||
            out_data.increase_credit !== head_window.increase_credit)
          flag_error("window mismatch", head_window, out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d windows pending",
               cycle_count, expected_windows.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    last_ack = '0;
    cwnd = rwa_pkg::WINDOW_INIT;
    credit = '0;
    ssthresh = rwa_pkg::THRESH_INIT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    walk_script(0, OPEN_ROWS - 1);
    run_phase(16'd300, 350, 63, 1'b0, 1'b1, 1'b0);
    run_phase(16'd1, 300, 63, 1'b0, 1'b0, 1'b0);
    run_phase(16'hFFFF, 350, 63, 1'b0, 1'b0, 1'b1);
    run_phase(16'd2, 350, 65535, 1'b0, 1'b0, 1'b0);
    quiet <= 1'b1;
    run_phase(16'($urandom_range(2, 65535)), 350, 65535, 1'b1, 1'b0, 1'b0);
    walk_script(OPEN_ROWS, SCRIPT_ROWS - 1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d acks sent, %0d windows checked, %0d threshold writes, %0d errors",
             acks_sent, windows_checked, threshold_writes, errors);
    $display("covered slow start, additive increase, sequence wrap and 16-bit saturation");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: reno_window_ack_update_core.f
rtl/rwa_pkg.sv
rtl/rwa_divider.sv
rtl/reno_window_ack_update_core.sv
rtl/rwa_checker.sv
bench/tb_reno_window_ack_update_core.sv
